FILE: rtl/ws2812_pixel_frame_serializer_top_macros.svh
// Assertion macros used by the serializer checker.
// Each macro expects a signal named clk (and rst_n for the gated form) in scope.
`ifndef WS2812_PIXEL_FRAME_SERIALIZER_TOP_MACROS_SVH
`define WS2812_PIXEL_FRAME_SERIALIZER_TOP_MACROS_SVH

// Checked only while reset is released
`define WSPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define WSPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/wsps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WS2812 serializer package
// Field widths, request and register codes, and parameter defaults.
// ----------------------------------------------------------------------------
package wsps_pkg;

  // Payload widths
  localparam int TYPE_W   = 2;
  localparam int PIX_W    = 8;
  localparam int CHAN_W   = 8;
  localparam int COLOUR_W = 24;
  localparam int DUTY_W   = 16;
  localparam int COUNT_W  = 9;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 16;

  // Pixel store depth, fixed by the pixel index width
  localparam int STORE_DEPTH = 1 << PIX_W;

  // Request codes
  localparam logic [TYPE_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_START = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_SLOT  = 2'd2;

  // Register indexes
  localparam logic [CFG_AW-1:0] CFG_HIGH  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_LOW   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_COUNT = 2'd2;

  // Register reset values
  localparam logic [COUNT_W-1:0] COUNT_RST = 9'd256;

  // Parameter defaults
  localparam int MAX_PIXELS_DEF     = 256;
  localparam int RESET_SLOTS_DEF    = 500;
  localparam int BITS_PER_PIXEL_DEF = 24;

endpackage
`default_nettype wire

FILE: rtl/wsps_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WS2812 serializer channels
// Request, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface wsps_in_if import wsps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] req_type;
  logic [PIX_W-1:0]  first_pixel;
  logic [PIX_W-1:0]  last_pixel;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, req_type, first_pixel, last_pixel, red, green, blue,
                  input ready);
  modport sink   (input valid, req_type, first_pixel, last_pixel, red, green, blue,
                  output ready);
endinterface

interface wsps_out_if import wsps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              accepted;
  logic [DUTY_W-1:0] duty;
  logic              last_slot;
  logic              busy_res;

  modport source (output valid, accepted, duty, last_slot, busy_res, input ready);
  modport sink   (input valid, accepted, duty, last_slot, busy_res, output ready);
endinterface

interface wsps_cfg_if import wsps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] addr;
  logic [CFG_DW-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/ws2812_pixel_frame_serializer_top.sv
// Slot request: result loaded into the output register in the cycle after it is accepted;
// one per cycle while idle and results are taken. Range write: one pixel per cycle on
// the live store write port. Start: one pixel per cycle copied live store -> frame store.
// Start with zero pixels, rejected and idle requests: result straight from idle.
// Reset (rst_n low, synchronous) clears control state and the live store valid bits;
// configuration registers return to high 0, low 0, pixel count 256.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WS2812 pixel frame serializer
// Pixel store with range writes, frame snapshot on start, and one PWM compare
// value per slot request (24 colour bits per pixel, then a zero reset tail).
// ----------------------------------------------------------------------------
module ws2812_pixel_frame_serializer_top
  import wsps_pkg::*;
#(
  parameter int MAX_PIXELS     = MAX_PIXELS_DEF,
  parameter int RESET_SLOTS    = RESET_SLOTS_DEF,
  parameter int BITS_PER_PIXEL = BITS_PER_PIXEL_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  wsps_in_if.sink    in_ch,
  wsps_out_if.source out_ch,
  wsps_cfg_if.sink   cfg_ch
);

  localparam int CAP_I = (MAX_PIXELS < STORE_DEPTH) ? MAX_PIXELS : STORE_DEPTH;
  localparam logic [COUNT_W-1:0] CAP = COUNT_W'(CAP_I);
  localparam int BW    = $clog2(BITS_PER_PIXEL);
  localparam int EXT_W = 1 << BW;
  localparam int TW    = $clog2(RESET_SLOTS + 1);
  localparam logic [BW-1:0] BIT_TOP  = BW'(BITS_PER_PIXEL - 1);
  localparam logic [TW-1:0] TAIL_END = TW'(RESET_SLOTS - 1);

  typedef enum logic [1:0] {S_IDLE, S_FILL, S_COPY} state_t;

  // Configuration registers
  logic [DUTY_W-1:0]  high_r, low_r;
  logic [COUNT_W-1:0] pcount_r;

  // Control and frame state
  state_t             state_r, state_nxt;
  logic [DUTY_W-1:0]  fhigh_r, fhigh_nxt, flow_r, flow_nxt;
  logic [COUNT_W-1:0] fcount_r, fcount_nxt;
  logic               busy_r, busy_nxt;
  logic               data_ph_r, data_ph_nxt;
  logic [COUNT_W-1:0] pix_r, pix_nxt;
  logic [BW-1:0]      bit_r, bit_nxt;
  logic [TW-1:0]      tail_r, tail_nxt;
  logic [COLOUR_W-1:0] cur_r, cur_nxt;
  logic               fresh_r, fresh_nxt;
  logic [PIX_W-1:0]   fill_idx_r, fill_idx_nxt, fill_last_r, fill_last_nxt;
  logic [COLOUR_W-1:0] fill_col_r, fill_col_nxt;
  logic [COUNT_W-1:0] cp_rd_r, cp_rd_nxt;
  logic               cp_wv_r, cp_wv_nxt;
  logic [PIX_W-1:0]   cp_wa_r, cp_wa_nxt;
  logic               lv_r, lv_nxt;
  logic [STORE_DEPTH-1:0] lval_r, lval_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic               o_acc_r, o_acc_nxt;
  logic [DUTY_W-1:0]  o_duty_r, o_duty_nxt;
  logic               o_last_r, o_last_nxt;
  logic               o_busy_r, o_busy_nxt;

  // Memory ports
  logic [COLOUR_W-1:0] live_mem [STORE_DEPTH];
  logic [COLOUR_W-1:0] frame_mem [STORE_DEPTH];
  logic                l_we, f_we;
  logic [PIX_W-1:0]    l_wa, l_ra, f_wa, f_ra;
  logic [COLOUR_W-1:0] l_wd, f_wd, l_rdata_r, f_rdata_r;

  // Helpers
  logic [COUNT_W-1:0] eff_count;
  logic               range_ok, in_ready, acc, produce;
  logic               p_acc, p_last, p_busy;
  logic [DUTY_W-1:0]  p_duty;
  logic [COLOUR_W-1:0] colour, cp_data;
  logic [EXT_W-1:0]   colour_ext;

  // Effective pixel count: clamp to the build maximum
  always_comb begin
    eff_count = (pcount_r > CAP) ? CAP : pcount_r;
  end

  assign range_ok   = ({1'b0, in_ch.last_pixel} < eff_count) &&
                      (in_ch.first_pixel <= in_ch.last_pixel);
  assign in_ready   = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign acc        = in_ch.valid && in_ready;
  assign colour     = fresh_r ? f_rdata_r : cur_r;
  assign colour_ext = EXT_W'(colour);
  assign cp_data    = lv_r ? l_rdata_r : '0;

  assign in_ch.ready     = in_ready;
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.accepted = o_acc_r;
  assign out_ch.duty     = o_duty_r;
  assign out_ch.last_slot = o_last_r;
  assign out_ch.busy_res = o_busy_r;

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    fhigh_nxt     = fhigh_r;
    flow_nxt      = flow_r;
    fcount_nxt    = fcount_r;
    busy_nxt      = busy_r;
    data_ph_nxt   = data_ph_r;
    pix_nxt       = pix_r;
    bit_nxt       = bit_r;
    tail_nxt      = tail_r;
    cur_nxt       = fresh_r ? f_rdata_r : cur_r;
    fresh_nxt     = 1'b0;
    fill_idx_nxt  = fill_idx_r;
    fill_last_nxt = fill_last_r;
    fill_col_nxt  = fill_col_r;
    cp_rd_nxt     = cp_rd_r;
    cp_wv_nxt     = 1'b0;
    cp_wa_nxt     = cp_wa_r;
    lval_nxt      = lval_r;
    produce       = 1'b0;
    p_acc         = 1'b0;
    p_duty        = '0;
    p_last        = 1'b0;
    p_busy        = busy_r;
    l_we          = 1'b0;
    l_wa          = fill_idx_r;
    l_wd          = fill_col_r;
    l_ra          = cp_rd_r[PIX_W-1:0];
    f_we          = 1'b0;
    f_wa          = cp_wa_r;
    f_wd          = cp_data;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_ch.req_type)
            REQ_WRITE: begin
              if (range_ok) begin
                fill_idx_nxt  = in_ch.first_pixel;
                fill_last_nxt = in_ch.last_pixel;
                fill_col_nxt  = {in_ch.green, in_ch.red, in_ch.blue};
                state_nxt     = S_FILL;
              end else begin
                produce = 1'b1;
              end
            end
            REQ_START: begin
              if (!busy_r) begin
                fhigh_nxt  = high_r;
                flow_nxt   = low_r;
                fcount_nxt = eff_count;
                if (eff_count == '0) begin
                  // Tail-only frame
                  busy_nxt    = 1'b1;
                  data_ph_nxt = 1'b0;
                  tail_nxt    = '0;
                  produce     = 1'b1;
                  p_acc       = 1'b1;
                  p_busy      = 1'b1;
                end else begin
                  cp_rd_nxt = '0;
                  state_nxt = S_COPY;
                end
              end else begin
                produce = 1'b1;
              end
            end
            REQ_SLOT: begin
              produce = 1'b1;
              if (busy_r) begin
                p_acc = 1'b1;
                if (data_ph_r) begin
                  p_duty = colour_ext[bit_r] ? fhigh_r : flow_r;
                  if (bit_r == '0) begin
                    bit_nxt = BIT_TOP;
                    if ((pix_r + COUNT_W'(1)) == fcount_r) begin
                      data_ph_nxt = 1'b0;
                      tail_nxt    = '0;
                    end else begin
                      // Prefetch the next pixel from the frame store
                      pix_nxt   = pix_r + COUNT_W'(1);
                      fresh_nxt = 1'b1;
                    end
                  end else begin
                    bit_nxt = bit_r - BW'(1);
                  end
                end else if (tail_r == TAIL_END) begin
                  p_last   = 1'b1;
                  busy_nxt = 1'b0;
                end else begin
                  tail_nxt = tail_r + TW'(1);
                end
                p_busy = busy_nxt;
              end
            end
            default: begin
              produce = 1'b1;
            end
          endcase
        end
      end
      S_FILL: begin
        // Write one pixel per cycle
        l_we               = 1'b1;
        lval_nxt[fill_idx_r] = 1'b1;
        if (fill_idx_r == fill_last_r) begin
          produce   = 1'b1;
          p_acc     = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          fill_idx_nxt = fill_idx_r + PIX_W'(1);
        end
      end
      S_COPY: begin
        // Read stage: issue live store reads
        if (cp_rd_r < fcount_r) begin
          cp_wv_nxt = 1'b1;
          cp_wa_nxt = cp_rd_r[PIX_W-1:0];
          cp_rd_nxt = cp_rd_r + COUNT_W'(1);
        end
        // Write stage: land data in the frame store
        if (cp_wv_r) begin
          f_we = 1'b1;
          if (cp_wa_r == '0) begin
            cur_nxt = cp_data;
          end
          if ({1'b0, cp_wa_r} == (fcount_r - COUNT_W'(1))) begin
            busy_nxt    = 1'b1;
            data_ph_nxt = 1'b1;
            pix_nxt     = '0;
            bit_nxt     = BIT_TOP;
            produce     = 1'b1;
            p_acc       = 1'b1;
            p_busy      = 1'b1;
            state_nxt   = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    f_ra   = pix_nxt[PIX_W-1:0];
    lv_nxt = lval_r[l_ra];

    // Output register: load on a finished request, drop when taken
    out_valid_nxt = out_valid_r;
    o_acc_nxt     = o_acc_r;
    o_duty_nxt    = o_duty_r;
    o_last_nxt    = o_last_r;
    o_busy_nxt    = o_busy_r;
    if (produce) begin
      out_valid_nxt = 1'b1;
      o_acc_nxt     = p_acc;
      o_duty_nxt    = p_duty;
      o_last_nxt    = p_last;
      o_busy_nxt    = p_busy;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      data_ph_r   <= 1'b0;
      fresh_r     <= 1'b0;
      cp_wv_r     <= 1'b0;
      lval_r      <= '0;
      out_valid_r <= 1'b0;
      high_r      <= '0;
      low_r       <= '0;
      pcount_r    <= COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      data_ph_r   <= data_ph_nxt;
      fresh_r     <= fresh_nxt;
      cp_wv_r     <= cp_wv_nxt;
      lval_r      <= lval_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.addr)
          CFG_HIGH:  high_r   <= cfg_ch.data;
          CFG_LOW:   low_r    <= cfg_ch.data;
          CFG_COUNT: pcount_r <= cfg_ch.data[COUNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
    fhigh_r     <= fhigh_nxt;
    flow_r      <= flow_nxt;
    fcount_r    <= fcount_nxt;
    pix_r       <= pix_nxt;
    bit_r       <= bit_nxt;
    tail_r      <= tail_nxt;
    cur_r       <= cur_nxt;
    fill_idx_r  <= fill_idx_nxt;
    fill_last_r <= fill_last_nxt;
    fill_col_r  <= fill_col_nxt;
    cp_rd_r     <= cp_rd_nxt;
    cp_wa_r     <= cp_wa_nxt;
    lv_r        <= lv_nxt;
    o_acc_r     <= o_acc_nxt;
    o_duty_r    <= o_duty_nxt;
    o_last_r    <= o_last_nxt;
    o_busy_r    <= o_busy_nxt;
  end

  // Live pixel store
  always_ff @(posedge clk) begin
    if (l_we) begin
      live_mem[l_wa] <= l_wd;
    end
    l_rdata_r <= live_mem[l_ra];
  end

  // Frame snapshot store
  always_ff @(posedge clk) begin
    if (f_we) begin
      frame_mem[f_wa] <= f_wd;
    end
    f_rdata_r <= frame_mem[f_ra];
  end

endmodule
`default_nettype wire

FILE: rtl/wsps_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WS2812 serializer port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
`include "ws2812_pixel_frame_serializer_top_macros.svh"

module wsps_checker
  import wsps_pkg::*;
(
  input wire              clk,
  input wire              rst_n,
  input wire              out_valid,
  input wire              out_ready,
  input wire              out_accepted,
  input wire [DUTY_W-1:0] out_duty,
  input wire              out_last_slot,
  input wire              out_busy_res
);

  // Hold a stalled result
  `WSPS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_duty) && $stable(out_last_slot), "stalled result changed")

  // The final slot is a valid slot and ends the frame
  `WSPS_ASSERT(a_last_ends, out_valid && out_last_slot |-> out_accepted && !out_busy_res, "last slot without frame end")

  // A refused request carries no duty and no frame end
  `WSPS_ASSERT(a_reject_zero, out_valid && !out_accepted |-> out_duty == '0 && !out_last_slot, "refused request carries data")

  // No result straight out of reset
  `WSPS_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result present after reset")

endmodule

bind ws2812_pixel_frame_serializer_top wsps_checker u_wsps_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_accepted  (out_ch.accepted),
  .out_duty      (out_ch.duty),
  .out_last_slot (out_ch.last_slot),
  .out_busy_res  (out_ch.busy_res)
);
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WS2812 pixel frame serializer testbench
// Drives range writes, frame starts, slot requests and register writes with
// random gaps and stalls on both channels. A scoreboard keeps its own pixel
// store and frame snapshot, predicts one result per accepted request and
// compares every field of each result in order.
// ----------------------------------------------------------------------------
module tb;
  import wsps_pkg::*;

  localparam int     CLK_HALF    = 5;
  localparam int     N_PIXELS    = MAX_PIXELS_DEF;
  localparam int     TAIL_SLOTS  = RESET_SLOTS_DEF;
  localparam int     PIX_BITS    = BITS_PER_PIXEL_DEF;
  localparam int     SETTLE_CYC  = 300;
  localparam int     RAND_ITEMS  = 2000;
  localparam int     RAND_FRAMES = 1;
  localparam longint CYCLE_LIMIT = 2000000;

  // Codes the package leaves unnamed
  localparam logic [TYPE_W-1:0] REQ_NONE   = 2'd3;
  localparam logic [CFG_AW-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [TYPE_W-1:0] kind;
    logic [PIX_W-1:0]  first;
    logic [PIX_W-1:0]  last;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_req_t;

  typedef struct packed {
    logic              accepted;
    logic [DUTY_W-1:0] duty;
    logic              last_slot;
    logic              busy;
  } slot_res_t;

  // --------------------------------------------------------------------------
  // Scoreboard: live store, frame snapshot and the queue of expected results
  // --------------------------------------------------------------------------
  class duty_scoreboard;
    bit [COLOUR_W-1:0] live_store [STORE_DEPTH];
    bit [COLOUR_W-1:0] frame_store [STORE_DEPTH];
    bit [DUTY_W-1:0]   high_reg;
    bit [DUTY_W-1:0]   low_reg;
    bit [DUTY_W-1:0]   frame_high;
    bit [DUTY_W-1:0]   frame_low;
    bit [COUNT_W-1:0]  count_reg;
    int                frame_len;
    int                slot_pos;
    bit                frame_busy;
    slot_res_t         pending_results [$];
    int                errors;

    function new();
      foreach (live_store[i]) begin
        live_store[i]  = '0;
        frame_store[i] = '0;
      end
      high_reg   = '0;
      low_reg    = '0;
      frame_high = '0;
      frame_low  = '0;
      count_reg  = COUNT_RST;
      frame_len  = 0;
      slot_pos   = 0;
      frame_busy = 1'b0;
      errors     = 0;
    endfunction

    // Pixel count clamped to the strip maximum
    function int strip_len();
      return (int'(count_reg) > N_PIXELS) ? N_PIXELS : int'(count_reg);
    endfunction

    function bit busy_now();
      return frame_busy;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void set_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
      case (addr)
        CFG_HIGH:  high_reg  = data;
        CFG_LOW:   low_reg   = data;
        CFG_COUNT: count_reg = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Work out the result of one accepted request and queue it
    function void note_request(pixel_req_t r);
      slot_res_t         res;
      int                i;
      int                data_slots;
      int                bit_idx;
      bit [COLOUR_W-1:0] colour;
      res = '0;
      case (r.kind)
        REQ_WRITE: begin
          if (int'(r.last) < strip_len() && r.first <= r.last) begin
            for (i = r.first; i <= r.last; i++) live_store[i] = {r.green, r.red, r.blue};
            res.accepted = 1'b1;
          end
        end
        REQ_START: begin
          // Snapshot store and duties; a start while busy changes nothing
          if (!frame_busy) begin
            frame_len   = strip_len();
            frame_store = live_store;
            frame_high  = high_reg;
            frame_low   = low_reg;
            slot_pos    = 0;
            frame_busy  = 1'b1;
            res.accepted = 1'b1;
          end
        end
        REQ_SLOT: begin
          if (frame_busy) begin
            data_slots   = frame_len * PIX_BITS;
            res.accepted = 1'b1;
            if (slot_pos < data_slots) begin
              bit_idx = PIX_BITS - 1 - slot_pos % PIX_BITS;
              colour  = frame_store[slot_pos / PIX_BITS];
              // Bits above the colour word send as zero
              if (bit_idx < COLOUR_W && colour[bit_idx]) res.duty = frame_high;
              else res.duty = frame_low;
            end
            if (slot_pos + 1 >= data_slots + TAIL_SLOTS) begin
              res.last_slot = 1'b1;
              frame_busy    = 1'b0;
              slot_pos      = 0;
            end else begin
              slot_pos++;
            end
          end
        end
        default: ;
      endcase
      res.busy = frame_busy;
      pending_results.push_back(res);
    endfunction

    // Compare one result with the oldest expectation
    function void check_result(slot_res_t got);
      slot_res_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: accepted %0d duty %0h last_slot %0d busy_res %0d",
               got.accepted, got.duty, got.last_slot, got.busy);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0d, actual %0d", want.accepted, got.accepted);
        errors++;
      end
      if (got.duty !== want.duty) begin
        $error("duty: expected %0h, actual %0h", want.duty, got.duty);
        errors++;
      end
      if (got.last_slot !== want.last_slot) begin
        $error("last_slot: expected %0d, actual %0d", want.last_slot, got.last_slot);
        errors++;
      end
      if (got.busy !== want.busy) begin
        $error("busy_res: expected %0d, actual %0d", want.busy, got.busy);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels and the block
  // --------------------------------------------------------------------------
  logic           clk = 1'b0;
  logic           rst_n;
  duty_scoreboard sb;
  bit             calm = 1'b0;
  int             rx_hold_len = 0;
  int             items_sent = 0;
  longint         cycle_cnt = 0;

  always #CLK_HALF clk = ~clk;

  wsps_in_if  in_ch ();
  wsps_out_if out_ch ();
  wsps_cfg_if cfg_ch ();

  ws2812_pixel_frame_serializer_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [CHAN_W-1:0] rnd_byte();
    return CHAN_W'($urandom);
  endfunction

  // Colour channel, biased towards the extremes
  function automatic logic [CHAN_W-1:0] pick_channel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  function automatic logic [DUTY_W-1:0] pick_duty();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return DUTY_W'($urandom);
    endcase
  endfunction

  function automatic int pick_count();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(7, 16);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  // Offer one request after an optional gap, hold it until taken
  task automatic issue(input logic [TYPE_W-1:0] kind,
                       input logic [PIX_W-1:0]  first,
                       input logic [PIX_W-1:0]  last,
                       input logic [CHAN_W-1:0] red,
                       input logic [CHAN_W-1:0] green,
                       input logic [CHAN_W-1:0] blue);
    pixel_req_t r;
    r = '{kind, first, last, red, green, blue};
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= r.kind;
    in_ch.first_pixel <= r.first;
    in_ch.last_pixel  <= r.last;
    in_ch.red         <= r.red;
    in_ch.green       <= r.green;
    in_ch.blue        <= r.blue;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(r);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= addr;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.set_reg(addr, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Pixel count with junk in the unused upper bits
  task automatic write_count(input int count);
    write_reg(CFG_COUNT, {(CFG_DW-COUNT_W)'($urandom), COUNT_W'(count)});
  endtask

  // Stop offering, wait for every result, then let any long write finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic drain_frame();
    while (sb.busy_now()) issue(REQ_SLOT, rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte(),
                                rnd_byte());
  endtask

  // Range write inside the strip, or an arbitrary one when the strip is empty
  task automatic send_good_write();
    int n;
    int lo;
    n = sb.strip_len();
    if (n == 0) begin
      issue(REQ_WRITE, rnd_byte(), rnd_byte(), pick_channel(), pick_channel(), pick_channel());
      return;
    end
    lo = $urandom_range(0, n - 1);
    issue(REQ_WRITE, PIX_W'(lo), PIX_W'($urandom_range(lo, n - 1)),
          pick_channel(), pick_channel(), pick_channel());
  endtask

  // Unused type, broken ranges, idle slots and starts while busy
  task automatic send_noise();
    int n;
    int lo;
    int hi;
    n = sb.strip_len();
    case ($urandom_range(0, 3))
      0: issue(REQ_NONE, rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
      1: begin
        lo = $urandom_range(1, 255);
        issue(REQ_WRITE, PIX_W'(lo), PIX_W'($urandom_range(0, lo - 1)),
              rnd_byte(), rnd_byte(), rnd_byte());
      end
      2: begin
        if (n < STORE_DEPTH) begin
          hi = $urandom_range(n, STORE_DEPTH - 1);
          issue(REQ_WRITE, PIX_W'($urandom_range(0, hi)), PIX_W'(hi),
                rnd_byte(), rnd_byte(), rnd_byte());
        end else begin
          issue(REQ_WRITE, 8'd255, 8'd0, rnd_byte(), rnd_byte(), rnd_byte());
        end
      end
      default: issue(sb.busy_now() ? REQ_START : REQ_SLOT, rnd_byte(), rnd_byte(),
                     rnd_byte(), rnd_byte(), rnd_byte());
    endcase
  endtask

  // One frame: new settings, a few writes, start, then slots to the end
  task automatic run_frame_episode(input int count, input bit squeeze);
    int n_writes;
    int k;
    settle();
    write_reg(CFG_HIGH, pick_duty());
    write_reg(CFG_LOW, pick_duty());
    write_count(count);
    n_writes = $urandom_range(1, 6);
    for (k = 0; k < n_writes; k++) begin
      if ($urandom_range(0, 3) == 0) send_noise();
      send_good_write();
    end
    if (count >= N_PIXELS) begin
      issue(REQ_WRITE, 8'd0, 8'd255, pick_channel(), pick_channel(), pick_channel());
      issue(REQ_WRITE, 8'd255, 8'd255, pick_channel(), pick_channel(), pick_channel());
    end
    issue(REQ_START, rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
    k = 0;
    while (sb.busy_now()) begin
      if ($urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 2))
          0:       send_good_write();
          1:       issue(REQ_START, rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte(),
                         rnd_byte());
          default: send_noise();
        endcase
      end else begin
        issue(REQ_SLOT, rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
      end
      k++;
      // Stall the result side for a long stretch while requests keep coming
      if (squeeze && k == 40) rx_hold_len = 400;
      // Pause until all results are in, then change a duty mid-frame
      if (squeeze && k == 300) begin
        settle();
        write_reg(CFG_HIGH, pick_duty());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int ep;
    sb = new();
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.req_type     <= '0;
    in_ch.first_pixel  <= '0;
    in_ch.last_pixel   <= '0;
    in_ch.red          <= '0;
    in_ch.green        <= '0;
    in_ch.blue         <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.addr        <= '0;
    cfg_ch.data        <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset state: idle slot, unused type, full clear, top pixel, reversed range
    issue(REQ_SLOT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    issue(REQ_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    issue(REQ_WRITE, 8'd0, 8'd255, 8'h00, 8'h00, 8'h00);
    issue(REQ_WRITE, 8'd255, 8'd255, 8'hFF, 8'hFF, 8'hFF);
    issue(REQ_WRITE, 8'd200, 8'd100, 8'hAA, 8'h55, 8'hAA);

    // Two-pixel strip with extreme duties
    settle();
    write_reg(CFG_UNUSED, 16'hBEEF);
    write_reg(CFG_HIGH, 16'hFFFF);
    write_reg(CFG_LOW, 16'h0000);
    write_count(2);
    issue(REQ_WRITE, 8'd2, 8'd2, 8'h12, 8'h34, 8'h56);
    issue(REQ_WRITE, 8'd255, 8'd255, 8'h12, 8'h34, 8'h56);
    issue(REQ_WRITE, 8'd0, 8'd1, 8'h00, 8'hFF, 8'hFF);
    issue(REQ_WRITE, 8'd1, 8'd1, 8'hFF, 8'h00, 8'h00);
    issue(REQ_SLOT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    issue(REQ_START, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    issue(REQ_START, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    // Write during the frame: store changes, frame keeps its snapshot
    issue(REQ_WRITE, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00);
    issue(REQ_SLOT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    issue(REQ_SLOT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    issue(REQ_NONE, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5);
    issue(REQ_SLOT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    drain_frame();
    issue(REQ_SLOT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);

    // Empty strip: every write rejected, frame is the reset tail alone
    settle();
    write_reg(CFG_HIGH, 16'h1234);
    write_count(0);
    issue(REQ_WRITE, 8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF);
    issue(REQ_START, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    drain_frame();

    // Count above the maximum: writes up to the top pixel still land
    settle();
    write_count(511);
    issue(REQ_WRITE, 8'd0, 8'd255, pick_channel(), pick_channel(), pick_channel());
    issue(REQ_WRITE, 8'd255, 8'd255, pick_channel(), pick_channel(), pick_channel());

    // Random frames, the first one under a long result stall
    ep = 0;
    while (ep < RAND_FRAMES || items_sent + 2 * TAIL_SLOTS < RAND_ITEMS) begin
      run_frame_episode(pick_count(), ep == 0);
      ep++;
    end

    // Closing frame with no idling on either side
    calm = 1'b1;
    run_frame_episode(pick_count(), 1'b0);
    settle();

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result side ready: random stall bursts, long hold on request
  initial begin : result_sink
    int hold;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_len > 0) begin
        hold        = rx_hold_len;
        rx_hold_len = 0;
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Check each result taken by the sink
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      sb.check_result({out_ch.accepted, out_ch.duty, out_ch.last_slot, out_ch.busy_res});
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
